// File: sv/mmt_pkg.sv
// ----------------------------------------------------------------------------
// mmt_pkg: shared types and constants of the math markup tokenizer
// Token record, token kinds, character codes and the keyword matcher.
// ----------------------------------------------------------------------------
package mmt_pkg;

   // token kinds
   localparam logic [5:0] KIND_END     = 6'd0;
   localparam logic [5:0] KIND_LPAREN  = 6'd1;
   localparam logic [5:0] KIND_RPAREN  = 6'd2;
   localparam logic [5:0] KIND_LBRACE  = 6'd3;
   localparam logic [5:0] KIND_RBRACE  = 6'd4;
   localparam logic [5:0] KIND_SLASH   = 6'd5;
   localparam logic [5:0] KIND_CARET   = 6'd6;
   localparam logic [5:0] KIND_UNDER   = 6'd7;
   localparam logic [5:0] KIND_CONTENT = 6'd8;
   localparam logic [5:0] KIND_KEY0    = 6'd9;

   // character codes
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_UP_A   = 8'h41;
   localparam logic [7:0] CH_UP_Z   = 8'h5A;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_LO_A   = 8'h61;
   localparam logic [7:0] CH_LO_Z   = 8'h7A;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;

   localparam logic [15:0] FIRST_LINE_RESET = 16'd1;

   // at most three tokens come out of one text word
   localparam int MAX_TOKENS = 3;
   // candidate token slots per word: old word, own token, last word, end
   localparam int CAND_SLOTS = 4;

   // keyword table
   localparam int KW_COUNT = 42;
   localparam int KW_MAX   = 7;

   typedef logic [8*KW_MAX-1:0] kw_text_type;

   // right-justified literals, first character in the highest used byte
   localparam kw_text_type KW_TEXT [KW_COUNT] = '{
      "sin", "cos", "tan", "sec", "csc", "cot", "sinh", "cosh", "tanh",
      "alpha", "beta", "Gamma", "gamma", "Delta", "delta", "epsilon", "zeta",
      "eta", "theta", "iota", "kappa", "Lambda", "lambda", "mu", "nu", "Xi",
      "xi", "Pi", "pi", "rho", "Sigma", "sigma", "tau", "Upsilon", "upsilon",
      "Phi", "phi", "chi", "Psi", "psi", "Omega", "omega"
   };

   localparam logic [2:0] KW_LEN [KW_COUNT] = '{
      3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4,
      3'd5, 3'd4, 3'd5, 3'd5, 3'd5, 3'd5, 3'd7, 3'd4,
      3'd3, 3'd5, 3'd4, 3'd5, 3'd6, 3'd6, 3'd2, 3'd2, 3'd2,
      3'd2, 3'd2, 3'd2, 3'd3, 3'd5, 3'd5, 3'd3, 3'd7, 3'd7,
      3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd5, 3'd5
   };

   typedef struct packed {
      logic [5:0]  kind;
      logic [15:0] start;
      logic [15:0] length;
      logic [15:0] line;
      logic        last;
   } tok_rec_type;

   // word: byte i at [8*i +: 8]; fits: word length is at most KW_MAX
   function automatic logic [5:0] match_kind(kw_text_type word, logic [2:0] len,
                                             logic fits);
      kw_text_type t;
      logic        hit;
      logic [5:0]  kind;
      kind = KIND_CONTENT;
      for (int k = 0; k < KW_COUNT; k++) begin
         t   = KW_TEXT[k] << (8 * (KW_MAX - int'(KW_LEN[k])));
         hit = fits && (len == KW_LEN[k]);
         for (int i = 0; i < KW_MAX; i++) begin
            if (i < int'(KW_LEN[k]) && word[8*i +: 8] != t[8*(KW_MAX-1-i) +: 8]) begin
               hit = 1'b0;
            end
         end
         if (hit) begin
            kind = 6'(int'(KIND_KEY0) + k);
         end
      end
      return kind;
   endfunction

   // clamp a position value to the 16-bit output fields
   function automatic logic [15:0] sat16(logic [31:0] v);
      return (|v[31:16]) ? 16'hFFFF : v[15:0];
   endfunction

endpackage

// File: sv/math_markup_tokenizer.sv
// ----------------------------------------------------------------------------
// math_markup_tokenizer: streaming tokenizer for a small math markup language
// Takes one text byte per word and gives tokens with kind, offset, length
// and line number; words are matched against trig and Greek keywords.
// ----------------------------------------------------------------------------
//
//  port group | dir | carries
//  -----------+-----+-------------------------------------------------------
//  req_*      | in  | one text byte, tlast on the last byte of a text
//  rsp_*      | out | one token, tlast on the last token caused by a byte
//  csr_*      | in  | first line number, loads the line counter at once
//
// A byte is taken in the cycle it arrives; its tokens (zero to three) are
// put into the token queue at that same edge, and the first shows on rsp_*
// in the next cycle if the queue was empty. Sustained rate is one byte per
// cycle while bytes average one token or fewer and rsp_tready is high, as the
// queue has one output port. req_tready drops only when the queue lacks room
// for three tokens. Reset is synchronous; the line counter comes up as 1.
//
module math_markup_tokenizer #(
   parameter int KEYWORD_BYTES = 7,   // 7..16, stored bytes of a word
   parameter int POSITION_BITS = 16,  // 8..32, byte offset and length counters
   parameter int QUEUE_DEPTH   = 8    // power of two, at least 4
) (
   input  logic        clock,
   input  logic        reset,
   // input byte stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] text_byte
   input  logic        req_tlast,    // end_of_text
   // token stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,    // [15:0] token_start, [31:16] token_length,
                                     // [47:32] token_line
   output logic [5:0]  rsp_tuser,    // [5:0] token_kind
   output logic        rsp_tlast,    // last_of_run
   // configuration
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data   // first_line
);

   localparam int PB  = POSITION_BITS;
   localparam int KBW = $clog2(KEYWORD_BYTES);
   localparam logic [PB-1:0] POS_MAX = '1;

   // ---------------- tokenizer state ----------------
   logic          word_open_ff;
   logic [7:0]    word_bytes_ff [KEYWORD_BYTES];   // only written bytes are meaningful
   logic [PB-1:0] word_length_ff;
   logic [PB-1:0] word_start_ff;
   logic [PB-1:0] byte_position_ff;
   logic [15:0]   line_count_ff;

   logic          word_open_in;
   logic [7:0]    word_bytes_in [KEYWORD_BYTES];
   logic [PB-1:0] word_length_in;
   logic [PB-1:0] word_start_in;
   logic [PB-1:0] byte_position_in;
   logic [15:0]   line_count_in;

   // ---------------- byte decode ----------------
   logic       acc;
   logic [7:0] in_byte;
   logic       is_alnum, is_blank, is_lf, is_word_head;
   logic [5:0] single_kind;

   // ---------------- per-byte work ----------------
   logic          cont, flush_old, new_word, own_tok;
   logic          open_mid;
   logic [PB-1:0] length_mid, start_mid, pos_mid;
   logic [15:0]   line_mid;
   mmt_pkg::kw_text_type old_text, mid_text;

   mmt_pkg::tok_rec_type cand [mmt_pkg::CAND_SLOTS];
   logic [mmt_pkg::CAND_SLOTS-1:0] cand_valid;
   logic        queue_room;
   mmt_pkg::tok_rec_type out_token;

   assign acc        = req_tvalid && req_tready;
   assign req_tready = queue_room;
   assign in_byte    = req_tdata;

   always_comb begin
      is_alnum = (in_byte >= mmt_pkg::CH_ZERO && in_byte <= mmt_pkg::CH_NINE) ||
                 (in_byte >= mmt_pkg::CH_UP_A && in_byte <= mmt_pkg::CH_UP_Z) ||
                 (in_byte >= mmt_pkg::CH_LO_A && in_byte <= mmt_pkg::CH_LO_Z);
      is_blank = (in_byte == mmt_pkg::CH_SPACE) || (in_byte == mmt_pkg::CH_CR) ||
                 (in_byte == mmt_pkg::CH_TAB);
      is_lf    = (in_byte == mmt_pkg::CH_LF);
      is_word_head = is_alnum || (in_byte == mmt_pkg::CH_LT) ||
                     (in_byte == mmt_pkg::CH_GT);
      unique case (in_byte)
         mmt_pkg::CH_LPAREN: single_kind = mmt_pkg::KIND_LPAREN;
         mmt_pkg::CH_RPAREN: single_kind = mmt_pkg::KIND_RPAREN;
         mmt_pkg::CH_LBRACE: single_kind = mmt_pkg::KIND_LBRACE;
         mmt_pkg::CH_RBRACE: single_kind = mmt_pkg::KIND_RBRACE;
         mmt_pkg::CH_SLASH:  single_kind = mmt_pkg::KIND_SLASH;
         mmt_pkg::CH_CARET:  single_kind = mmt_pkg::KIND_CARET;
         mmt_pkg::CH_UNDER:  single_kind = mmt_pkg::KIND_UNDER;
         default:            single_kind = mmt_pkg::KIND_CONTENT;
      endcase
   end

   always_comb begin
      // byte continues the open word, or closes it
      cont      = word_open_ff && is_alnum;
      flush_old = word_open_ff && !cont;
      new_word  = !cont && is_word_head;
      own_tok   = !cont && !is_blank && !is_lf && !is_word_head;

      // word and position after this byte, before any end-of-text cleanup
      word_bytes_in = word_bytes_ff;
      length_mid    = word_length_ff;
      start_mid     = word_start_ff;
      if (cont) begin
         if (word_length_ff < PB'(KEYWORD_BYTES)) begin
            word_bytes_in[word_length_ff[KBW-1:0]] = in_byte;
         end
         if (word_length_ff != POS_MAX) begin
            length_mid = word_length_ff + PB'(1);
         end
      end else if (new_word) begin
         word_bytes_in[0] = in_byte;
         length_mid       = PB'(1);
         start_mid        = byte_position_ff;
      end
      open_mid = cont || new_word;
      pos_mid  = (byte_position_ff == POS_MAX) ? byte_position_ff
                                               : byte_position_ff + PB'(1);
      line_mid = line_count_ff + 16'(!cont && is_lf);

      for (int i = 0; i < mmt_pkg::KW_MAX; i++) begin
         old_text[8*i +: 8] = word_bytes_ff[i];
         mid_text[8*i +: 8] = word_bytes_in[i];
      end

      // candidate tokens in output order
      cand_valid[0]  = flush_old;
      cand[0].kind   = mmt_pkg::match_kind(old_text, word_length_ff[2:0],
                          word_length_ff <= PB'(mmt_pkg::KW_MAX));
      cand[0].start  = mmt_pkg::sat16(32'(word_start_ff));
      cand[0].length = mmt_pkg::sat16(32'(word_length_ff));
      cand[0].line   = line_count_ff;
      cand[0].last   = 1'b0;

      cand_valid[1]  = own_tok;
      cand[1].kind   = single_kind;
      cand[1].start  = mmt_pkg::sat16(32'(byte_position_ff));
      cand[1].length = 16'd1;
      cand[1].line   = line_count_ff;
      cand[1].last   = 1'b0;

      // end of text closes a word still open after this byte
      cand_valid[2]  = req_tlast && open_mid;
      cand[2].kind   = mmt_pkg::match_kind(mid_text, length_mid[2:0],
                          length_mid <= PB'(mmt_pkg::KW_MAX));
      cand[2].start  = mmt_pkg::sat16(32'(start_mid));
      cand[2].length = mmt_pkg::sat16(32'(length_mid));
      cand[2].line   = line_mid;
      cand[2].last   = 1'b0;

      // end token: start is the text length
      cand_valid[3]  = req_tlast;
      cand[3].kind   = mmt_pkg::KIND_END;
      cand[3].start  = mmt_pkg::sat16(32'(pos_mid));
      cand[3].length = 16'd0;
      cand[3].line   = line_mid;
      cand[3].last   = 1'b0;

      // a new text starts from offset zero with no word open
      if (req_tlast) begin
         word_open_in     = 1'b0;
         word_length_in   = '0;
         word_start_in    = '0;
         byte_position_in = '0;
      end else begin
         word_open_in     = open_mid;
         word_length_in   = length_mid;
         word_start_in    = start_mid;
         byte_position_in = pos_mid;
      end

      // a configuration write reloads the line counter
      if (csr_wr_en) begin
         line_count_in = csr_wr_data;
      end else if (acc) begin
         line_count_in = line_mid;
      end else begin
         line_count_in = line_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_open_ff     <= 1'b0;
         word_length_ff   <= '0;
         word_start_ff    <= '0;
         byte_position_ff <= '0;
         line_count_ff    <= mmt_pkg::FIRST_LINE_RESET;
      end else begin
         if (acc) begin
            word_open_ff     <= word_open_in;
            word_length_ff   <= word_length_in;
            word_start_ff    <= word_start_in;
            byte_position_ff <= byte_position_in;
         end
         line_count_ff <= line_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         word_bytes_ff <= word_bytes_in;
      end
   end

   // ---------------- token queue ----------------
   mmt_token_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (cand_valid & {mmt_pkg::CAND_SLOTS{acc}}),
      .push_data  (cand),
      .push_room  (queue_room),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_token  (out_token)
   );

   assign rsp_tdata = {out_token.line, out_token.length, out_token.start};
   assign rsp_tuser = out_token.kind;
   assign rsp_tlast = out_token.last;

   // ---------------- assertions ----------------
   // the end token is queued at the edge that takes the last byte
   a_end_queued: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> rsp_tvalid)
      else $error("end of text gave no token");

   // a text end leaves the tokenizer at offset zero with no word open
   a_text_restart: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=>
         (byte_position_ff == '0) && !word_open_ff && (word_length_ff == '0))
      else $error("text end did not restart position");

   // an open word always holds at least one byte
   a_word_nonempty: assert property (@(posedge clock) disable iff (reset)
      word_open_ff |-> (word_length_ff != '0))
      else $error("open word with zero length");

endmodule

// File: sv/mmt_token_queue.sv
// ----------------------------------------------------------------------------
// mmt_token_queue: token queue with multi-word push
// Packs up to four candidate tokens in order, marks the last one, and hands
// them out one per cycle if out_ready is high. DEPTH must be a power of two.
// ----------------------------------------------------------------------------
module mmt_token_queue #(
   parameter int DEPTH = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [mmt_pkg::CAND_SLOTS-1:0] push_valid,
   input  mmt_pkg::tok_rec_type push_data [mmt_pkg::CAND_SLOTS],
   output logic                push_room,
   output logic                out_valid,
   input  logic                out_ready,
   output mmt_pkg::tok_rec_type out_token
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   mmt_pkg::tok_rec_type mem_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;

   logic [1:0] slot [mmt_pkg::CAND_SLOTS];
   logic [mmt_pkg::CAND_SLOTS-1:0] is_last;
   mmt_pkg::tok_rec_type push_marked [mmt_pkg::CAND_SLOTS];
   logic [2:0] push_count;
   logic       pop;

   always_comb begin
      push_count = 3'd0;
      for (int c = 0; c < mmt_pkg::CAND_SLOTS; c++) begin
         slot[c]    = push_count[1:0];
         push_count = push_count + 3'(push_valid[c]);
      end
      for (int c = 0; c < mmt_pkg::CAND_SLOTS; c++) begin
         is_last[c] = push_valid[c];
         for (int d = c + 1; d < mmt_pkg::CAND_SLOTS; d++) begin
            if (push_valid[d]) begin
               is_last[c] = 1'b0;
            end
         end
         push_marked[c]      = push_data[c];
         push_marked[c].last = is_last[c];
      end
   end

   assign pop       = out_valid && out_ready;
   assign out_valid = (count_ff != '0);
   assign out_token = mem_ff[rd_ptr_ff];
   // room for a full burst of one text word
   assign push_room = (int'(count_ff) <= DEPTH - mmt_pkg::MAX_TOKENS);

   always_ff @(posedge clock) begin
      for (int c = 0; c < mmt_pkg::CAND_SLOTS; c++) begin
         if (push_valid[c]) begin
            mem_ff[wr_ptr_ff + AW'(slot[c])] <= push_marked[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + AW'(push_count);
         rd_ptr_ff <= rd_ptr_ff + AW'(pop);
         count_ff  <= count_ff + CW'(push_count) - CW'(pop);
      end
   end

endmodule
